// ===== hdl/assert_macros.svh =====
// assertion macros shared by the radix converter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define SITRD_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the same edge
`define SITRD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define SITRD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sitrd_pkg.sv =====
// types, constants and tables of the radix converter
package sitrd_pkg;

	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 64;
	localparam int DIGIT_SLOTS = 32;
	localparam int CNT_W       = 6;
	localparam int IDX_W       = 5;

	localparam logic [1:0] REG_RADIX   = 2'd0;
	localparam logic [1:0] REG_SYM_LOW = 2'd1;
	localparam logic [1:0] REG_SYM_HI  = 2'd2;

	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;
	localparam logic [4:0] MIN_RADIX = 5'd2;

	localparam logic [4:0]  RADIX_RST   = 5'd10;
	localparam logic [63:0] SYM_LOW_RST = 64'h3736353433323130;
	localparam logic [63:0] SYM_HI_RST  = 64'h0000000000003938;

	typedef struct packed {
		logic [4:0]  radix;
		logic [63:0] sym_low;
		logic [63:0] sym_high;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic fix;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic neg;
		logic out_free;
		logic last_digit;
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_FIX,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// floor(2^32 / r), zero where the radix is unusable
	function automatic logic [31:0] recip(input logic [4:0] r);
		logic [31:0] m;
		unique case (r)
			5'd2:    m = 32'h80000000;
			5'd3:    m = 32'h55555555;
			5'd4:    m = 32'h40000000;
			5'd5:    m = 32'h33333333;
			5'd6:    m = 32'h2AAAAAAA;
			5'd7:    m = 32'h24924924;
			5'd8:    m = 32'h20000000;
			5'd9:    m = 32'h1C71C71C;
			5'd10:   m = 32'h19999999;
			5'd11:   m = 32'h1745D174;
			5'd12:   m = 32'h15555555;
			5'd13:   m = 32'h13B13B13;
			5'd14:   m = 32'h12492492;
			5'd15:   m = 32'h11111111;
			5'd16:   m = 32'h10000000;
			default: m = 32'h00000000;
		endcase
		return m;
	endfunction

endpackage

// ===== hdl/sitrd_regs.sv =====
// configuration registers, read mux and base validity check
module sitrd_regs import sitrd_pkg::*; #(
	parameter int MAX_RADIX = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg,
	output logic              base_ok
);

	logic [4:0]  radix_q;
	logic [63:0] sym_low_q;
	logic [63:0] sym_high_q;
	logic [1:0]  reg_idx;
	logic        wr_en;
	logic [7:0]  syms [16];
	logic        bad_sym;
	logic        dup_sym;

	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= RADIX_RST;
			sym_low_q  <= SYM_LOW_RST;
			sym_high_q <= SYM_HI_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RADIX:   radix_q    <= pwdata[4:0];
				REG_SYM_LOW: sym_low_q  <= pwdata;
				REG_SYM_HI:  sym_high_q <= pwdata;
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RADIX:   prdata = {59'd0, radix_q};
			REG_SYM_LOW: prdata = sym_low_q;
			REG_SYM_HI:  prdata = sym_high_q;
			default:     prdata = '0;
		endcase
	end

	// checks the symbols in use: zero, '+' or '-' is rejected, and each pair is compared
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			syms[i]     = sym_low_q[8*i +: 8];
			syms[i + 8] = sym_high_q[8*i +: 8];
		end
		bad_sym = 1'b0;
		dup_sym = 1'b0;
		for (int i = 0; i < MAX_RADIX; i++) begin
			if (5'(i) < radix_q) begin
				if (syms[i] == 8'h00 || syms[i] == SYM_PLUS || syms[i] == SYM_MINUS)
					bad_sym = 1'b1;
				for (int j = i + 1; j < MAX_RADIX; j++) begin
					if (5'(j) < radix_q && syms[j] == syms[i])
						dup_sym = 1'b1;
				end
			end
		end
	end

	assign base_ok = (radix_q >= MIN_RADIX) && (radix_q <= 5'(MAX_RADIX))
		&& !bad_sym && !dup_sym;

	assign cfg.radix    = radix_q;
	assign cfg.sym_low  = sym_low_q;
	assign cfg.sym_high = sym_high_q;

endmodule

// ===== hdl/sitrd_dp.sv =====
// datapath: reciprocal divide step, digit store and output register
`include "assert_macros.svh"
module sitrd_dp import sitrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  symbol,
	output logic        last
);

	logic [31:0]      quo_q;
	logic [31:0]      qest_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic [7:0]       symbol_q;
	logic             last_q;
	logic [3:0]       store [DIGIT_SLOTS];

	logic [63:0]      prod;
	logic [36:0]      back;
	logic [31:0]      rem_est;
	logic             fixup;
	logic [5:0]       rem_fin;
	logic [CNT_W-1:0] cnt_dec;
	logic [3:0]       rd_digit;
	logic [127:0]     sym_all;
	logic [7:0]       dig_sym;
	logic             out_load;

	// quotient estimate, low by at most one
	assign prod = {32'd0, quo_q} * {32'd0, recip(cfg.radix)};

	assign back    = {5'd0, qest_q} * {32'd0, cfg.radix};
	assign rem_est = quo_q - back[31:0];
	assign fixup   = rem_est[5:0] >= {1'b0, cfg.radix};
	assign rem_fin = fixup ? (rem_est[5:0] - {1'b0, cfg.radix}) : rem_est[5:0];

	assign cnt_dec  = cnt_q - CNT_W'(1);
	assign rd_digit = store[cnt_dec[IDX_W-1:0]];
	assign sym_all  = {cfg.sym_high, cfg.sym_low};
	assign dig_sym  = sym_all[{rd_digit, 3'b000} +: 8];
	assign out_load = cmd.emit_sign || cmd.emit_digit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			quo_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				cnt_q <= '0;
			else if (cmd.fix)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (cmd.emit_digit)
				cnt_q <= cnt_dec;
			if (cmd.load)
				quo_q <= value[31] ? (32'd0 - value) : value;
			else if (cmd.fix)
				quo_q <= qest_q + {31'd0, fixup};
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			neg_q <= value[31];
		if (cmd.mul)
			qest_q <= prod[63:32];
		if (cmd.fix)
			store[cnt_q[IDX_W-1:0]] <= rem_fin[3:0];
		if (cmd.emit_sign) begin
			symbol_q <= SYM_MINUS;
			last_q   <= 1'b0;
		end else if (cmd.emit_digit) begin
			symbol_q <= dig_sym;
			last_q   <= (cnt_q == CNT_W'(1));
		end
	end

	// quotient goes to zero exactly when the dividend is below the radix; also done at the last store slot
	assign status.div_done   = (quo_q < {27'd0, cfg.radix})
		|| (cnt_q == CNT_W'(DIGIT_SLOTS - 1));
	assign status.neg        = neg_q;
	assign status.out_free   = !out_valid_q || !out_stall;
	assign status.last_digit = (cnt_q == CNT_W'(1));

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign last      = last_q;

	`SITRD_ASSERT(a_cnt_range, cnt_q <= CNT_W'(DIGIT_SLOTS), "digit count past store depth")
	`SITRD_ASSERT_IMP(a_load_free, out_load, !out_valid_q || !out_stall,
		"output register overwritten while stalled")
	`SITRD_ASSERT_IMP(a_emit_cnt, cmd.emit_digit, cnt_q != '0, "digit emitted from empty store")

endmodule

// ===== hdl/sitrd_ctrl.sv =====
// controller: sequences check, divide loop and character emission
`include "assert_macros.svh"
module sitrd_ctrl import sitrd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic    base_ok,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = base_ok ? ST_MUL : ST_IDLE;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIX;
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				if (!status.div_done)
					state_d = ST_MUL;
				else if (status.neg)
					state_d = ST_SIGN;
				else
					state_d = ST_EMIT;
			end
			ST_SIGN: begin
				if (status.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit_digit = 1'b1;
					if (status.last_digit)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`SITRD_ASSERT_NXT(a_loop_back, state_q == ST_FIX && !status.div_done, state_q == ST_MUL,
		"divide loop left early")
	`SITRD_ASSERT_NXT(a_last_idle, cmd.emit_digit && status.last_digit, state_q == ST_IDLE,
		"controller busy after final character")
	`SITRD_ASSERT_NXT(a_bad_base, state_q == ST_CHECK && !base_ok, state_q == ST_IDLE,
		"invalid base not dropped")

endmodule

// ===== hdl/signed_int_to_radix_digits.sv =====
// top level of the signed integer to radix text converter
// Converts a signed 32-bit value to text in a configured radix (2 to 16), one
// output beat per character, most significant symbol first, with a leading
// '-' for negatives and last set on the final character. Registers sit on an
// APB-style port at byte addresses 0 (radix), 8 (symbols for digits 0..7) and
// 16 (symbols for digits 8..15); write them only while the block is idle. An
// invalid base (radix below 2 or above MAX_RADIX, a used symbol that is zero,
// '+' or '-', or two equal used symbols) drops the value with no output, going
// from the check state back to idle. Otherwise in_stall stays high while the
// divide loop yields one digit per pass (reciprocal multiply, then back-multiply
// and a single correction) and while the sign and digits are emitted; the
// characters leave through the output register at one per cycle while out_stall
// is low. The last character may wait in the output register while the next
// value is already accepted.
module signed_int_to_radix_digits import sitrd_pkg::*; #(
	parameter int MAX_RADIX = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	// input beat
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  value,
	// output beat
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          symbol,
	output logic                last
);

	cfg_t    cfg;
	logic    base_ok;
	cmd_t    cmd;
	status_t status;

	// writes complete in the access phase, no wait states
	assign pready = 1'b1;

	sitrd_regs #(
		.MAX_RADIX(MAX_RADIX)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg),
		.base_ok (base_ok)
	);

	// sequencer: check, divide loop, sign, digits in reverse
	sitrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.base_ok  (base_ok),
		.status   (status),
		.cmd      (cmd)
	);

	// magnitude, divide step, digit store and output register
	sitrd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.status    (status),
		.value     ($unsigned(value)),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.symbol    (symbol),
		.last      (last)
	);

endmodule
